// ----- rtl/assert_macros.svh -----
// Assertion helpers, clocked on clk_i and held off while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset
`define PSACT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition in one cycle is followed by another in the next
`define PSACT_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) else $error(msg);

`endif

// ----- rtl/psact_pkg.sv -----
package psact_pkg;

  localparam int unsigned DEFAULT_DEPTH   = 64;
  localparam int unsigned DEFAULT_COUNT_W = 16;
  localparam int unsigned ADDR_W          = 32;
  localparam int unsigned THR_W           = 16;
  localparam logic [THR_W-1:0] THR_RESET  = 16'd3;

  localparam logic REQ_RECORD = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_UNUSED = 2'd2
  } status_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

// ----- rtl/psact_ctrl.sv -----
module psact_ctrl import psact_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_UPDATE = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        // hold until the output register can take the result
        cmd_o.commit = stat_i.out_free;
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/psact_dp.sv -----
module psact_dp import psact_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEFAULT_DEPTH,
  parameter int unsigned COUNT_WIDTH = DEFAULT_COUNT_W,
  localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH),
  localparam int unsigned USED_W = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output stat_t                  stat_o,
  input  logic                   cfg_we_i,
  input  logic [THR_W-1:0]       cfg_wdata_i,
  input  logic                   req_type_i,
  input  logic [ADDR_W-1:0]      src_addr_i,
  input  logic                   failed_i,
  input  logic [IDX_W-1:0]       read_index_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [IDX_W-1:0]       entry_index_o,
  output logic [ADDR_W-1:0]      entry_addr_o,
  output logic [COUNT_WIDTH-1:0] attempt_count_o,
  output logic [COUNT_WIDTH-1:0] failure_count_o,
  output logic                   suspicious_o,
  output logic                   new_entry_o,
  output logic [1:0]             status_o,
  output logic [USED_W-1:0]      entries_used_o
);

  localparam int unsigned CMP_W = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;

  logic [THR_W-1:0]  thr_q;
  logic [USED_W-1:0] used_q, used_d;

  // Key cells for the parallel lookup
  logic [ADDR_W-1:0]      cam_q [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] hit;
  logic                   any_hit;
  logic [IDX_W-1:0]       hit_idx, rd_addr;

  // Entry memory, one read port registered at capture
  logic [ADDR_W-1:0]      key_mem  [TABLE_DEPTH];
  logic [COUNT_WIDTH-1:0] att_mem  [TABLE_DEPTH];
  logic [COUNT_WIDTH-1:0] fail_mem [TABLE_DEPTH];
  logic [ADDR_W-1:0]      key_rd_q;
  logic [COUNT_WIDTH-1:0] att_rd_q, fail_rd_q;

  // Captured transaction
  logic              req_read_q, failed_q, hit_q;
  logic [ADDR_W-1:0] addr_q;
  logic [IDX_W-1:0]  ridx_q, hit_idx_q;

  logic                   out_valid_q;
  logic [IDX_W-1:0]       res_idx;
  logic [ADDR_W-1:0]      res_addr;
  logic [COUNT_WIDTH-1:0] res_att, res_fail, att_inc, fail_inc;
  logic                   res_new, res_sus;
  status_e                res_status;
  logic                   read_ok, full, mem_we;

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit[i] = (USED_W'(i) < used_q) && (cam_q[i] == src_addr_i);
      if (hit[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
    any_hit = |hit;
    if (req_type_i == REQ_READ) begin
      rd_addr = read_index_i;
    end else if (any_hit) begin
      rd_addr = hit_idx;
    end else begin
      rd_addr = used_q[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_read_q <= (req_type_i == REQ_READ);
      addr_q     <= src_addr_i;
      failed_q   <= failed_i;
      ridx_q     <= read_index_i;
      hit_q      <= any_hit;
      hit_idx_q  <= hit_idx;
      key_rd_q   <= key_mem[rd_addr];
      att_rd_q   <= att_mem[rd_addr];
      fail_rd_q  <= fail_mem[rd_addr];
    end
    if (mem_we) begin
      key_mem[res_idx]  <= addr_q;
      att_mem[res_idx]  <= res_att;
      fail_mem[res_idx] <= res_fail;
    end
    if (cmd_i.commit && res_new) begin
      cam_q[res_idx] <= addr_q;
    end
  end

  always_comb begin
    att_inc  = (att_rd_q == '1) ? att_rd_q : att_rd_q + COUNT_WIDTH'(1);
    fail_inc = (fail_rd_q == '1) ? fail_rd_q : fail_rd_q + COUNT_WIDTH'(1);
    read_ok  = USED_W'(ridx_q) < used_q;
    full     = (used_q == USED_W'(TABLE_DEPTH));

    res_idx    = '0;
    res_addr   = addr_q;
    res_att    = '0;
    res_fail   = '0;
    res_new    = 1'b0;
    res_status = STATUS_OK;
    mem_we     = 1'b0;
    used_d     = used_q;

    if (req_read_q) begin
      res_idx = ridx_q;
      if (read_ok) begin
        res_addr = key_rd_q;
        res_att  = att_rd_q;
        res_fail = fail_rd_q;
      end else begin
        res_addr   = '0;
        res_status = STATUS_UNUSED;
      end
    end else if (hit_q) begin
      res_idx  = hit_idx_q;
      res_att  = att_inc;
      res_fail = failed_q ? fail_inc : fail_rd_q;
      mem_we   = cmd_i.commit;
    end else if (full) begin
      // drop the address, table untouched
      res_status = STATUS_FULL;
    end else begin
      res_idx  = used_q[IDX_W-1:0];
      res_att  = COUNT_WIDTH'(1);
      res_fail = COUNT_WIDTH'(failed_q);
      res_new  = 1'b1;
      mem_we   = cmd_i.commit;
      used_d   = used_q + USED_W'(1);
    end
    res_sus = CMP_W'(res_fail) > CMP_W'(thr_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= THR_RESET;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (cmd_i.commit) begin
        used_q      <= used_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      entry_index_o   <= res_idx;
      entry_addr_o    <= res_addr;
      attempt_count_o <= res_att;
      failure_count_o <= res_fail;
      suspicious_o    <= res_sus;
      new_entry_o     <= res_new;
      status_o        <= res_status;
      entries_used_o  <= used_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

endmodule

// ----- rtl/per_source_attempt_counter_table.sv -----
// Per-source attempt counter table. Each record transaction looks up its IPv4
// source address in up to TABLE_DEPTH entries; a hit bumps the attempt count (and
// the failure count when failed_i is set), a miss takes the next free entry, and
// a miss on a full table is dropped with status 1. A read transaction returns the
// entry at read_index_i, or status 2 when that index is not in use. Counters
// saturate at all ones; suspicious_o is set when the failure count is strictly
// above the threshold written on cfg_wdata_i (3 after reset). One transaction is
// handled at a time: the accept cycle runs the parallel key compare and reads
// the entry memory, the next cycle updates the counters, writes the entry back
// and loads the output register. The next transaction is accepted in the cycle
// after that write, since its lookup needs the entry just inserted. A full
// output register holds the update cycle. The entry memory needs no clearing
// after reset.
module per_source_attempt_counter_table import psact_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEFAULT_DEPTH,
  parameter int unsigned COUNT_WIDTH = DEFAULT_COUNT_W,
  localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH),
  localparam int unsigned USED_W = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [THR_W-1:0]       cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   req_type_i,
  input  logic [ADDR_W-1:0]      src_addr_i,
  input  logic                   failed_i,
  input  logic [IDX_W-1:0]       read_index_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [IDX_W-1:0]       entry_index_o,
  output logic [ADDR_W-1:0]      entry_addr_o,
  output logic [COUNT_WIDTH-1:0] attempt_count_o,
  output logic [COUNT_WIDTH-1:0] failure_count_o,
  output logic                   suspicious_o,
  output logic                   new_entry_o,
  output logic [1:0]             status_o,
  output logic [USED_W-1:0]      entries_used_o
);

  `include "assert_macros.svh"

  cmd_t  cmd;
  stat_t stat;

  psact_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  psact_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .req_type_i      (req_type_i),
    .src_addr_i      (src_addr_i),
    .failed_i        (failed_i),
    .read_index_i    (read_index_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .entry_index_o   (entry_index_o),
    .entry_addr_o    (entry_addr_o),
    .attempt_count_o (attempt_count_o),
    .failure_count_o (failure_count_o),
    .suspicious_o    (suspicious_o),
    .new_entry_o     (new_entry_o),
    .status_o        (status_o),
    .entries_used_o  (entries_used_o)
  );

  `PSACT_ASSERT(a_no_capture_on_commit, !(cmd.capture && cmd.commit), "capture and commit together")
  `PSACT_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "accepted while busy")
  `PSACT_ASSERT_NEXT(a_commit_loads_output, cmd.commit, out_valid_o, "commit lost its result")
  `PSACT_ASSERT(a_full_drop, !(out_valid_o && status_o == STATUS_FULL) || (entries_used_o == USED_W'(TABLE_DEPTH) && !new_entry_o), "drop reported on a table with room")

endmodule

// ----- tb/per_source_attempt_counter_table_tb.sv -----
`timescale 1ns / 1ps

module per_source_attempt_counter_table_tb;
  import psact_pkg::*;

  localparam int unsigned DEPTH         = DEFAULT_DEPTH;
  localparam int unsigned COUNT_W       = DEFAULT_COUNT_W;
  localparam int unsigned IDX_W         = $clog2(DEPTH);
  localparam int unsigned USED_W        = $clog2(DEPTH + 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned LONG_HOLD     = 150;
  localparam int unsigned PHASE_ITEMS   = 300;
  localparam int unsigned SAT_ITEMS     = 40;
  localparam int unsigned SHOW_LIMIT    = 10;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] addr;
    logic              failed;
    logic [IDX_W-1:0]  read_index;
  } request_t;

  typedef struct packed {
    logic [IDX_W-1:0]   index;
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] attempts;
    logic [COUNT_W-1:0] failures;
    logic               suspicious;
    logic               new_entry;
    status_e            status;
    logic [USED_W-1:0]  used;
  } result_t;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [THR_W-1:0]   cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic               out_ready_i = 1'b0;
  request_t           offered     = '0;
  logic               in_ready_o;
  logic               out_valid_o;
  logic [IDX_W-1:0]   entry_index_o;
  logic [ADDR_W-1:0]  entry_addr_o;
  logic [COUNT_W-1:0] attempt_count_o;
  logic [COUNT_W-1:0] failure_count_o;
  logic               suspicious_o;
  logic               new_entry_o;
  logic [1:0]         status_o;
  logic [USED_W-1:0]  entries_used_o;

  // Shadow of the address table, kept in step with accepted transactions
  logic [ADDR_W-1:0]  shadow_addr     [DEPTH];
  logic [COUNT_W-1:0] shadow_attempts [DEPTH];
  logic [COUNT_W-1:0] shadow_failures [DEPTH];
  int unsigned        shadow_used = 0;
  logic [THR_W-1:0]   shadow_thr  = THR_RESET;

  request_t          queued_requests[$];
  result_t           awaited_entries[$];
  logic [ADDR_W-1:0] seen_addrs[$];

  logic        idle_en   = 1'b1;
  logic        hold_req  = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned send_gap  = 0;
  int unsigned recv_gap  = 0;
  int unsigned quiet     = 0;
  int unsigned fail_count = 0;

  per_source_attempt_counter_table uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (offered.kind),
    .src_addr_i      (offered.addr),
    .failed_i        (offered.failed),
    .read_index_i    (offered.read_index),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .entry_index_o   (entry_index_o),
    .entry_addr_o    (entry_addr_o),
    .attempt_count_o (attempt_count_o),
    .failure_count_o (failure_count_o),
    .suspicious_o    (suspicious_o),
    .new_entry_o     (new_entry_o),
    .status_o        (status_o),
    .entries_used_o  (entries_used_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic logic [COUNT_W-1:0] sat_bump(input logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  // Work out the entry a transaction reports and update the shadow table
  function automatic result_t update_attempt_table(input request_t rq);
    result_t r;
    int      hit;
    int      i;
    r   = '0;
    hit = -1;
    if (rq.kind == REQ_READ) begin
      r.index = rq.read_index;
      if (rq.read_index < shadow_used) begin
        r.addr       = shadow_addr[rq.read_index];
        r.attempts   = shadow_attempts[rq.read_index];
        r.failures   = shadow_failures[rq.read_index];
        r.suspicious = shadow_failures[rq.read_index] > shadow_thr;
        r.status     = STATUS_OK;
      end else begin
        r.status = STATUS_UNUSED;
      end
    end else begin
      for (i = 0; i < shadow_used; i++) begin
        if (hit < 0 && shadow_addr[i] == rq.addr) hit = i;
      end
      r.addr = rq.addr;
      if (hit >= 0) begin
        shadow_attempts[hit] = sat_bump(shadow_attempts[hit]);
        if (rq.failed) shadow_failures[hit] = sat_bump(shadow_failures[hit]);
        r.index      = IDX_W'(hit);
        r.attempts   = shadow_attempts[hit];
        r.failures   = shadow_failures[hit];
        r.suspicious = shadow_failures[hit] > shadow_thr;
        r.status     = STATUS_OK;
      end else if (shadow_used >= DEPTH) begin
        // Table full: drop the address and leave the table alone
        r.status = STATUS_FULL;
      end else begin
        shadow_addr[shadow_used]     = rq.addr;
        shadow_attempts[shadow_used] = COUNT_W'(1);
        shadow_failures[shadow_used] = COUNT_W'(rq.failed);
        r.index      = IDX_W'(shadow_used);
        r.attempts   = COUNT_W'(1);
        r.failures   = COUNT_W'(rq.failed);
        r.suspicious = {{(THR_W-1){1'b0}}, rq.failed} > shadow_thr;
        r.new_entry  = 1'b1;
        r.status     = STATUS_OK;
        shadow_used++;
      end
    end
    r.used = USED_W'(shadow_used);
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 25);
  endfunction

  function automatic request_t record_req(input logic [ADDR_W-1:0] a, input logic f);
    request_t rq;
    rq.kind       = REQ_RECORD;
    rq.addr       = a;
    rq.failed     = f;
    rq.read_index = IDX_W'($urandom_range(DEPTH - 1, 0));
    return rq;
  endfunction

  function automatic request_t read_req(input logic [IDX_W-1:0] idx);
    request_t rq;
    rq.kind       = REQ_READ;
    rq.addr       = $urandom();
    rq.failed     = 1'($urandom_range(1, 0));
    rq.read_index = idx;
    return rq;
  endfunction

  // Mostly repeat addresses already seen so entries build up counts
  function automatic request_t random_request();
    request_t    rq;
    int unsigned fresh_pct;
    fresh_pct = (seen_addrs.size() < DEPTH) ? 30 : 10;
    if ($urandom_range(99, 0) < 25) begin
      rq = read_req(IDX_W'($urandom_range(DEPTH - 1, 0)));
    end else begin
      rq = record_req($urandom(), 1'($urandom_range(1, 0)));
      if (seen_addrs.size() == 0 || $urandom_range(99, 0) < fresh_pct) begin
        seen_addrs.push_back(rq.addr);
      end else begin
        rq.addr = seen_addrs[$urandom_range(seen_addrs.size() - 1, 0)];
      end
    end
    return rq;
  endfunction

  task automatic wait_drained();
    while (queued_requests.size() != 0 || in_valid_i || awaited_entries.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_thr = value;
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : drive_requests
    logic     vld_next;
    request_t req_next;
    vld_next = in_valid_i;
    req_next = offered;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        awaited_entries.push_back(update_attempt_table(offered));
        vld_next = 1'b0;
        send_gap = idle_en ? pick_gap() : 0;
      end
      if (!vld_next) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (queued_requests.size() > 0) begin
          req_next = queued_requests.pop_front();
          vld_next = 1'b1;
        end
      end
    end
    in_valid_i <= vld_next;
    offered    <= req_next;
  end

  always @(posedge clk_i) begin : check_results
    logic    rdy_next;
    result_t got;
    result_t want;
    rdy_next = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got.index      = entry_index_o;
        got.addr       = entry_addr_o;
        got.attempts   = attempt_count_o;
        got.failures   = failure_count_o;
        got.suspicious = suspicious_o;
        got.new_entry  = new_entry_o;
        got.status     = status_e'(status_o);
        got.used       = entries_used_o;
        if (awaited_entries.size() == 0) begin
          fail_count++;
          if (fail_count <= SHOW_LIMIT)
            $display("%0t: unexpected transaction idx=%0d addr=%h", $realtime,
                     got.index, got.addr);
        end else begin
          want = awaited_entries.pop_front();
          if (got.index !== want.index || got.addr !== want.addr ||
              got.attempts !== want.attempts || got.failures !== want.failures ||
              got.suspicious !== want.suspicious || got.new_entry !== want.new_entry ||
              got.status !== want.status || got.used !== want.used) begin
            fail_count++;
            if (fail_count <= SHOW_LIMIT) begin
              $display("%0t: exp idx=%0d addr=%h att=%0d fail=%0d sus=%b new=%b st=%0d used=%0d",
                       $realtime, want.index, want.addr, want.attempts, want.failures,
                       want.suspicious, want.new_entry, want.status, want.used);
              $display("%0t: got idx=%0d addr=%h att=%0d fail=%0d sus=%b new=%b st=%0d used=%0d",
                       $realtime, got.index, got.addr, got.attempts, got.failures,
                       got.suspicious, got.new_entry, got.status, got.used);
            end
          end
        end
      end
      // Hold off once for a long stretch so the block backs up
      if (hold_left > 0) begin
        hold_left--;
      end else if (hold_req && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
      end else begin
        recv_gap = idle_en ? pick_gap() : 0;
        rdy_next = (recv_gap == 0);
      end
    end
    out_ready_i <= rdy_next;
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin : run_test
    logic [THR_W-1:0] thr_plan [6];
    int               p;
    thr_plan = '{16'd0, 16'hFFFF, 16'd5, 16'd1, 16'd12, 16'd2};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty table, fresh entries, the threshold boundary at its reset value
    queued_requests.push_back(read_req(0));
    queued_requests.push_back(read_req(IDX_W'(DEPTH - 1)));
    queued_requests.push_back(record_req('0, 1'b0));
    queued_requests.push_back(record_req('1, 1'b1));
    queued_requests.push_back(record_req('1, 1'b1));
    queued_requests.push_back(record_req('1, 1'b1));
    queued_requests.push_back(record_req('1, 1'b1));
    queued_requests.push_back(record_req('0, 1'b0));
    queued_requests.push_back(read_req(1));
    queued_requests.push_back(read_req(2));
    queued_requests.push_back(read_req(0));
    queued_requests.push_back(record_req(32'hAAAA_AAAA, 1'b1));
    queued_requests.push_back(record_req(32'h5555_5555, 1'b0));
    queued_requests.push_back(read_req(3));
    queued_requests.push_back(read_req(IDX_W'(DEPTH - 1)));

    for (p = 0; p < 6; p++) begin
      write_threshold(thr_plan[p]);
      idle_en = (p != 3);
      if (p == 1) hold_req = 1'b1;
      repeat (PHASE_ITEMS) queued_requests.push_back(random_request());
    end

    // Pile failed attempts onto one address, then move the threshold around it
    write_threshold('1);
    idle_en = 1'b0;
    repeat (SAT_ITEMS) queued_requests.push_back(record_req('1, 1'b1));
    queued_requests.push_back(read_req(1));
    write_threshold(16'hFFFE);
    idle_en = 1'b1;
    queued_requests.push_back(record_req('1, 1'b0));
    queued_requests.push_back(read_req(1));
    queued_requests.push_back(read_req(0));
    write_threshold('0);
    queued_requests.push_back(read_req(1));
    queued_requests.push_back(read_req(0));
    queued_requests.push_back(read_req(IDX_W'(DEPTH - 1)));
    wait_drained();

    if (awaited_entries.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
